// ===== rtl/sngoa_pkg.sv =====
`timescale 1ns / 1ps
package sngoa_pkg;

  localparam int unsigned FFT_SIZE_DEF    = 256;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LAM_W      = 16;
  localparam int unsigned RATIO_W    = 10;
  localparam int unsigned POW_W      = 48;
  localparam int unsigned TWB        = 26;

  localparam logic [LAM_W-1:0]   LAM_RST   = 16'd65470;
  localparam logic [RATIO_W-1:0] RATIO_RST = 10'd10;
  localparam logic [63:0]        TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTH = 2'd0,
    REG_GATE   = 2'd1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_OUT,
    ST_LOAD,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_WP,
    ST_BF_WQ,
    ST_G_RD,
    ST_G_SQ,
    ST_G_PW,
    ST_G_PP,
    ST_G_AVG,
    ST_G_TP,
    ST_G_CMP,
    ST_SW_RD,
    ST_SW_WP,
    ST_SW_WQ,
    ST_OLA
  } state_e;

  function automatic logic [63:0] tw_arg(int unsigned k, int unsigned lg);
    logic [63:0] m;
    logic [63:0] half;
    logic [63:0] quarter;
    half    = 64'd1 << (lg - 1);
    quarter = 64'd1 << (lg - 2);
    m = (64'(k) <= quarter) ? 64'(k) : half - 64'(k);
    return (m * TWO_PI_Q30) >> lg;
  endfunction

  function automatic logic signed [TWB-1:0] tw_sin_q24(int unsigned k, int unsigned lg);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] s;
    x  = tw_arg(k, lg);
    x2 = (x * x) >> 30;
    t  = x;
    s  = $signed(x);
    for (int n = 1; n <= 8; n++) begin
      t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        s = s - $signed(t);
      end else begin
        s = s + $signed(t);
      end
    end
    s = (s + 64'sd32) >>> 6;
    return s[TWB-1:0];
  endfunction

  function automatic logic signed [TWB-1:0] tw_cos_q24(int unsigned k, int unsigned lg);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] s;
    x  = tw_arg(k, lg);
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    s  = $signed(t);
    for (int n = 1; n <= 9; n++) begin
      t = ((t * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n[0]) begin
        s = s - $signed(t);
      end else begin
        s = s + $signed(t);
      end
    end
    s = (s + 64'sd32) >>> 6;
    if (64'(k) > (64'd1 << (lg - 2))) begin
      s = -s;
    end
    return s[TWB-1:0];
  endfunction

endpackage

// ===== rtl/sngoa_in_if.sv =====
`timescale 1ns / 1ps
interface sngoa_in_if #(
  parameter int unsigned SAMPLE_BITS = sngoa_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// ===== rtl/sngoa_out_if.sv =====
`timescale 1ns / 1ps
interface sngoa_out_if #(
  parameter int unsigned SAMPLE_BITS = sngoa_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          out_valid;

  modport source (output valid, output sample_out, output out_valid, input ready);
  modport sink (input valid, input sample_out, input out_valid, output ready);
endinterface

// ===== rtl/spectral_noise_gate_overlap_add.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                      Handshake
// in_ch     in   sample_in                    valid/ready
// out_ch    out  sample_out, out_valid        valid/ready
// cfg       in   cfg_idx_i, cfg_data_i        cfg_we_i, no back-pressure
//
// An item is accepted, then its result is loaded into the free output register.
// Every FFT_SIZE/2 items a frame runs on the work memory with one butterfly
// unit: a load, 2*log2(FFT_SIZE)*FFT_SIZE/2 butterflies, a gate pass over
// every bin, a pass over every bin to reorder the spectrum and an overlap-add.
// Reset clears control state only; no clearing pass, first frame reads zeros.
// A stalled output holds the result while the next transaction is accepted.
module spectral_noise_gate_overlap_add #(
  parameter int unsigned FFT_SIZE    = sngoa_pkg::FFT_SIZE_DEF,
  parameter int unsigned SAMPLE_BITS = sngoa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sngoa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sngoa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  sngoa_in_if.sink                            in_ch,
  sngoa_out_if.source                         out_ch
);

  localparam int unsigned LG   = $clog2(FFT_SIZE);
  localparam int unsigned HOP  = FFT_SIZE / 2;
  localparam int unsigned LGH  = LG - 1;
  localparam int unsigned CW   = LG + 1;
  localparam int unsigned SGW  = $clog2(LG);
  localparam int unsigned W    = SAMPLE_BITS + LG + 2;
  localparam int unsigned AW   = (W + 1 > 25) ? W + 1 : 25;
  localparam int unsigned PWW  = sngoa_pkg::POW_W;
  localparam int unsigned TW   = sngoa_pkg::RATIO_W + PWW;
  localparam int unsigned XW   = W + 34;
  localparam int unsigned TWB  = sngoa_pkg::TWB;
  localparam logic signed [XW-1:0] S32_HI = XW'(64'sd2147483647);
  localparam logic signed [XW-1:0] S32_LO = XW'(-64'sd2147483648);
  localparam logic signed [33:0] SHI = (34'sd1 <<< (SAMPLE_BITS - 1)) - 34'sd1;
  localparam logic signed [33:0] SLO = -SHI - 34'sd1;

  sngoa_pkg::state_e state_q, state_d;

  logic [sngoa_pkg::LAM_W-1:0]   lam_q;
  logic [sngoa_pkg::RATIO_W-1:0] ratio_q;

  logic [CW-1:0]  n_q, n_d, cnt_q, cnt_d;
  logic [CW:0]    n_inc;
  logic [SGW-1:0] stage_q, stage_d;
  logic           inv_q, inv_d, first_q, first_d;
  logic           proc_q, ov_q;
  logic [LG-1:0]  base_q;
  logic           out_vq, out_vd, out_ld;
  logic           ld_vq, ld_vd, ol_vq, ol_vd;
  logic           in_acc;

  logic signed [SAMPLE_BITS-1:0] frame_mem [FFT_SIZE];
  logic [2*W-1:0]                work_mem [FFT_SIZE];
  logic [PWW-1:0]                noise_mem [FFT_SIZE];
  logic signed [31:0]            tail_mem [HOP];
  logic signed [SAMPLE_BITS-1:0] queue_mem [HOP];

  logic signed [SAMPLE_BITS-1:0] fr_rd_q, queue_rd_q, out_s_q;
  logic                          out_f_q;
  logic [2*W-1:0]                rda_q, rdb_q;
  logic [PWW-1:0]                noise_rd_q;
  logic signed [31:0]            tail_rd_q;

  logic [LG-1:0]  ra, rb, wa;
  logic [2*W-1:0] wd;
  logic           work_we;

  logic [LG-1:0]  ld_idx_q, ld_rev, sw_rev;
  logic           sw_en;
  logic [LGH-1:0] ol_idx_q;

  logic [LG-1:0]  bfx, hmask, bp, bq, kx;
  logic [LG-2:0]  tw_k;
  logic signed [TWB-1:0] cos_rom [HOP];
  logic signed [TWB-1:0] sin_rom [HOP];
  logic signed [TWB-1:0] c_q, w_q;
  logic signed [W-1:0]   pr, pi, qr, qi;

  logic signed [W-1:0] re_a, im_a, re_b, im_b;
  logic signed [W:0]   rex, imx;
  logic [AW-1:0]       arx, aix;
  logic                big_q;
  logic [47:0]         sqr_q, sqi_q;
  logic [48:0]         pw_sum;
  logic [PWW-1:0]      pw_q, np, avg_q;
  logic [16:0]         nl;
  logic [39:0]         pp0_q, pp1_q;
  logic [40:0]         pp2_q, pp3_q;
  logic [63:0]         tot;
  logic [33:0]         gp0_q, gp1_q;
  logic [TW-1:0]       thr;
  logic                gate_off;

  logic signed [31:0]  ola_a, ola_b, tail_v;
  logic signed [32:0]  ola_sum;
  logic signed [SAMPLE_BITS-1:0] ola_q;

  function automatic logic signed [31:0] sat32(logic signed [W-1:0] v);
    logic signed [XW-1:0] h;
    h = (XW'(v) + XW'(2'sd1)) >>> 1;
    if (h > S32_HI) begin
      h = S32_HI;
    end else if (h < S32_LO) begin
      h = S32_LO;
    end
    return h[31:0];
  endfunction

  for (genvar g = 0; g < HOP; g++) begin : g_tw
    assign cos_rom[g] = sngoa_pkg::tw_cos_q24(g, LG);
    assign sin_rom[g] = sngoa_pkg::tw_sin_q24(g, LG);
  end

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_q == sngoa_pkg::ST_IDLE);

  assign out_ch.valid      = out_vq;
  assign out_ch.sample_out = out_s_q;
  assign out_ch.out_valid  = out_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lam_q   <= sngoa_pkg::LAM_RST;
      ratio_q <= sngoa_pkg::RATIO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sngoa_pkg::REG_SMOOTH: lam_q   <= cfg_data_i[sngoa_pkg::LAM_W-1:0];
        sngoa_pkg::REG_GATE:   ratio_q <= cfg_data_i[sngoa_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_inc = (CW+1)'(n_q) + (CW+1)'(1);
  assign n_d   = (n_inc >= (CW+1)'(2 * FFT_SIZE)) ? CW'(n_inc - (CW+1)'(FFT_SIZE))
                                                   : CW'(n_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sngoa_pkg::ST_IDLE;
      n_q     <= '0;
      cnt_q   <= '0;
      stage_q <= '0;
      inv_q   <= 1'b0;
      first_q <= 1'b1;
      proc_q  <= 1'b0;
      ov_q    <= 1'b0;
      base_q  <= '0;
      out_vq  <= 1'b0;
      ld_vq   <= 1'b0;
      ol_vq   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      stage_q <= stage_d;
      inv_q   <= inv_d;
      first_q <= first_d;
      out_vq  <= out_vd;
      ld_vq   <= ld_vd;
      ol_vq   <= ol_vd;
      if (in_acc) begin
        n_q    <= n_d;
        base_q <= n_inc[LG-1:0];
        ov_q   <= (n_q >= CW'(FFT_SIZE));
        proc_q <= (n_q >= CW'(FFT_SIZE - 1)) && (n_inc[LGH-1:0] == '0);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    stage_d = stage_q;
    inv_d   = inv_q;
    first_d = first_q;
    out_vd  = out_vq && !out_ch.ready;
    out_ld  = 1'b0;
    ld_vd   = 1'b0;
    ol_vd   = 1'b0;
    unique case (state_q)
      sngoa_pkg::ST_IDLE: begin
        if (in_acc) state_d = sngoa_pkg::ST_OUT;
      end
      sngoa_pkg::ST_OUT: begin
        if (!out_vq || out_ch.ready) begin
          out_ld = 1'b1;
          out_vd = 1'b1;
          if (proc_q) begin
            state_d = sngoa_pkg::ST_LOAD;
            cnt_d   = '0;
          end else begin
            state_d = sngoa_pkg::ST_IDLE;
          end
        end
      end
      sngoa_pkg::ST_LOAD: begin
        if (cnt_q != CW'(FFT_SIZE)) begin
          ld_vd = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end else begin
          state_d = sngoa_pkg::ST_BF_RD;
          cnt_d   = '0;
          stage_d = '0;
          inv_d   = 1'b0;
        end
      end
      sngoa_pkg::ST_BF_RD:  state_d = sngoa_pkg::ST_BF_MUL;
      sngoa_pkg::ST_BF_MUL: state_d = sngoa_pkg::ST_BF_WP;
      sngoa_pkg::ST_BF_WP:  state_d = sngoa_pkg::ST_BF_WQ;
      sngoa_pkg::ST_BF_WQ: begin
        state_d = sngoa_pkg::ST_BF_RD;
        if (cnt_q[LG-2:0] == '1) begin
          cnt_d = '0;
          if (stage_q == SGW'(LG - 1)) begin
            stage_d = '0;
            state_d = inv_q ? sngoa_pkg::ST_OLA : sngoa_pkg::ST_G_RD;
          end else begin
            stage_d = stage_q + SGW'(1);
          end
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      sngoa_pkg::ST_G_RD:  state_d = sngoa_pkg::ST_G_SQ;
      sngoa_pkg::ST_G_SQ:  state_d = sngoa_pkg::ST_G_PW;
      sngoa_pkg::ST_G_PW:  state_d = sngoa_pkg::ST_G_PP;
      sngoa_pkg::ST_G_PP:  state_d = sngoa_pkg::ST_G_AVG;
      sngoa_pkg::ST_G_AVG: state_d = sngoa_pkg::ST_G_TP;
      sngoa_pkg::ST_G_TP:  state_d = sngoa_pkg::ST_G_CMP;
      sngoa_pkg::ST_G_CMP: begin
        if (cnt_q[LG-1:0] == '1) begin
          cnt_d   = '0;
          inv_d   = 1'b1;
          state_d = sngoa_pkg::ST_SW_RD;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = sngoa_pkg::ST_G_RD;
        end
      end
      sngoa_pkg::ST_SW_RD: state_d = sngoa_pkg::ST_SW_WP;
      sngoa_pkg::ST_SW_WP: state_d = sngoa_pkg::ST_SW_WQ;
      sngoa_pkg::ST_SW_WQ: begin
        if (cnt_q[LG-1:0] == '1) begin
          cnt_d   = '0;
          state_d = sngoa_pkg::ST_BF_RD;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = sngoa_pkg::ST_SW_RD;
        end
      end
      sngoa_pkg::ST_OLA: begin
        if (cnt_q != CW'(HOP)) begin
          ol_vd = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end else begin
          state_d = sngoa_pkg::ST_IDLE;
          first_d = 1'b0;
        end
      end
      default: state_d = sngoa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) frame_mem[n_q[LG-1:0]] <= in_ch.sample_in;
    fr_rd_q  <= frame_mem[base_q + cnt_q[LG-1:0]];
    ld_idx_q <= cnt_q[LG-1:0];
    ol_idx_q <= cnt_q[LGH-1:0];
    if (state_q == sngoa_pkg::ST_IDLE) queue_rd_q <= queue_mem[n_q[LGH-1:0]];
    if (out_ld) begin
      out_s_q <= ov_q ? queue_rd_q : '0;
      out_f_q <= ov_q;
    end
  end

  always_comb begin
    for (int b = 0; b < LG; b++) begin
      ld_rev[b] = ld_idx_q[LG-1-b];
      sw_rev[b] = cnt_q[LG-1-b];
    end
    sw_en = sw_rev > cnt_q[LG-1:0];
  end

  always_comb begin
    bfx   = {1'b0, cnt_q[LG-2:0]};
    hmask = (LG'(1) << stage_q) - LG'(1);
    bp    = (((bfx >> stage_q) << 1) << stage_q) | (bfx & hmask);
    bq    = bp | (LG'(1) << stage_q);
    kx    = (bfx & hmask) << (SGW'(LG - 1) - stage_q);
    tw_k  = kx[LG-2:0];
  end

  always_comb begin
    ra = {1'b0, cnt_q[LGH-1:0]};
    rb = {1'b1, cnt_q[LGH-1:0]};
    case (state_q) inside
      sngoa_pkg::ST_BF_RD, sngoa_pkg::ST_BF_MUL, sngoa_pkg::ST_BF_WP,
      sngoa_pkg::ST_BF_WQ: begin
        ra = bp;
        rb = bq;
      end
      sngoa_pkg::ST_G_RD, sngoa_pkg::ST_G_SQ, sngoa_pkg::ST_G_PW, sngoa_pkg::ST_G_PP,
      sngoa_pkg::ST_G_AVG, sngoa_pkg::ST_G_TP, sngoa_pkg::ST_G_CMP: begin
        ra = cnt_q[LG-1:0];
        rb = cnt_q[LG-1:0];
      end
      sngoa_pkg::ST_SW_RD, sngoa_pkg::ST_SW_WP, sngoa_pkg::ST_SW_WQ: begin
        ra = cnt_q[LG-1:0];
        rb = sw_rev;
      end
      default: ;
    endcase
  end

  always_comb begin
    work_we = 1'b0;
    wa      = bp;
    wd      = {pr, pi};
    if (ld_vq) begin
      work_we = 1'b1;
      wa      = ld_rev;
      wd      = {W'(fr_rd_q), {W{1'b0}}};
    end else if (state_q == sngoa_pkg::ST_BF_WP) begin
      work_we = 1'b1;
    end else if (state_q == sngoa_pkg::ST_BF_WQ) begin
      work_we = 1'b1;
      wa      = bq;
      wd      = {qr, qi};
    end else if (state_q == sngoa_pkg::ST_G_CMP && gate_off) begin
      work_we = 1'b1;
      wa      = cnt_q[LG-1:0];
      wd      = '0;
    end else if (state_q == sngoa_pkg::ST_SW_WP && sw_en) begin
      work_we = 1'b1;
      wa      = cnt_q[LG-1:0];
      wd      = rdb_q;
    end else if (state_q == sngoa_pkg::ST_SW_WQ && sw_en) begin
      work_we = 1'b1;
      wa      = sw_rev;
      wd      = rda_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_we) work_mem[wa] <= wd;
    rda_q <= work_mem[ra];
    rdb_q <= work_mem[rb];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sngoa_pkg::ST_BF_RD) begin
      c_q <= cos_rom[tw_k];
      w_q <= inv_q ? sin_rom[tw_k] : -sin_rom[tw_k];
    end
  end

  assign re_a = rda_q[2*W-1:W];
  assign im_a = rda_q[W-1:0];
  assign re_b = rdb_q[2*W-1:W];
  assign im_b = rdb_q[W-1:0];

  sngoa_bfly #(
    .W (W)
  ) u_bfly (
    .clk_i     (clk_i),
    .cap_i     (state_q == sngoa_pkg::ST_BF_MUL),
    .inverse_i (inv_q),
    .ar_i      (re_a),
    .ai_i      (im_a),
    .br_i      (re_b),
    .bi_i      (im_b),
    .c_i       (c_q),
    .w_i       (w_q),
    .pr_o      (pr),
    .pi_o      (pi),
    .qr_o      (qr),
    .qi_o      (qi)
  );

  always_comb begin
    rex      = (W+1)'(re_a);
    imx      = (W+1)'(im_a);
    arx      = AW'($unsigned(rex[W] ? -rex : rex));
    aix      = AW'($unsigned(imx[W] ? -imx : imx));
    pw_sum   = 49'(sqr_q) + 49'(sqi_q);
    np       = first_q ? '0 : noise_rd_q;
    nl       = 17'd65536 - 17'(lam_q);
    tot      = 64'(pp0_q) + (64'(pp1_q) << 24) + 64'(pp2_q) + (64'(pp3_q) << 24)
             + 64'd32768;
    thr      = TW'(gp0_q) + (TW'(gp1_q) << 24);
    gate_off = TW'(pw_q) < thr;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sngoa_pkg::ST_G_SQ) begin
      big_q <= (|arx[AW-1:24]) || (|aix[AW-1:24]);
      sqr_q <= arx[23:0] * arx[23:0];
      sqi_q <= aix[23:0] * aix[23:0];
    end
    if (state_q == sngoa_pkg::ST_G_PW) begin
      pw_q <= (big_q || pw_sum[48]) ? '1 : pw_sum[47:0];
    end
    if (state_q == sngoa_pkg::ST_G_PP) begin
      pp0_q <= lam_q * np[23:0];
      pp1_q <= lam_q * np[47:24];
      pp2_q <= nl * pw_q[23:0];
      pp3_q <= nl * pw_q[47:24];
    end
    if (state_q == sngoa_pkg::ST_G_AVG) begin
      avg_q <= tot[63:16];
    end
    if (state_q == sngoa_pkg::ST_G_TP) begin
      gp0_q <= ratio_q * avg_q[23:0];
      gp1_q <= ratio_q * avg_q[47:24];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sngoa_pkg::ST_G_AVG) noise_mem[cnt_q[LG-1:0]] <= tot[63:16];
    noise_rd_q <= noise_mem[cnt_q[LG-1:0]];
  end

  always_comb begin
    ola_a   = sat32(re_a);
    ola_b   = sat32(re_b);
    tail_v  = first_q ? '0 : tail_rd_q;
    ola_sum = 33'(tail_v) + 33'(ola_a);
    if (34'(ola_sum) > SHI) begin
      ola_q = SHI[SAMPLE_BITS-1:0];
    end else if (34'(ola_sum) < SLO) begin
      ola_q = SLO[SAMPLE_BITS-1:0];
    end else begin
      ola_q = ola_sum[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ol_vq) begin
      queue_mem[ol_idx_q] <= ola_q;
      tail_mem[ol_idx_q]  <= ola_b;
    end
    tail_rd_q <= tail_mem[cnt_q[LGH-1:0]];
  end

  a_accept_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == sngoa_pkg::ST_OUT)
    else $error("accepted transaction did not move to result stage");

  a_no_work_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_we |-> (state_q != sngoa_pkg::ST_IDLE && state_q != sngoa_pkg::ST_OUT))
    else $error("work memory written outside frame processing");

  a_first_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sngoa_pkg::ST_OLA && state_d == sngoa_pkg::ST_IDLE) |=> !first_q)
    else $error("first-frame flag still set after overlap-add");

endmodule

// ===== rtl/sngoa_bfly.sv =====
`timescale 1ns / 1ps
module sngoa_bfly #(
  parameter int unsigned W = 26
) (
  input  logic                                 clk_i,
  input  logic                                 cap_i,
  input  logic                                 inverse_i,
  input  logic signed [W-1:0]                  ar_i,
  input  logic signed [W-1:0]                  ai_i,
  input  logic signed [W-1:0]                  br_i,
  input  logic signed [W-1:0]                  bi_i,
  input  logic signed [sngoa_pkg::TWB-1:0]     c_i,
  input  logic signed [sngoa_pkg::TWB-1:0]     w_i,
  output logic signed [W-1:0]                  pr_o,
  output logic signed [W-1:0]                  pi_o,
  output logic signed [W-1:0]                  qr_o,
  output logic signed [W-1:0]                  qi_o
);

  localparam int unsigned PW = W + sngoa_pkg::TWB;
  localparam int unsigned MW = PW - 24;
  localparam int unsigned SW = MW + 2;
  localparam logic signed [PW-1:0] RND = PW'(32'sd8388608);

  logic signed [PW-1:0] m_rc_q, m_iw_q, m_rw_q, m_ic_q;
  logic signed [W-1:0]  ar_q, ai_q;
  logic                 inv_q;
  logic signed [MW:0]   tr, ti;
  logic signed [SW-1:0] s0, s1, d0, d1;

  function automatic logic signed [MW-1:0] mq(logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = (p + RND) >>> 24;
    return r[MW-1:0];
  endfunction

  function automatic logic signed [W-1:0] fin(logic signed [SW-1:0] v, logic inv);
    logic signed [SW-1:0] h;
    h = (v + SW'(2'sd1)) >>> 1;
    return inv ? h[W-1:0] : v[W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      m_rc_q <= PW'(br_i) * PW'(c_i);
      m_iw_q <= PW'(bi_i) * PW'(w_i);
      m_rw_q <= PW'(br_i) * PW'(w_i);
      m_ic_q <= PW'(bi_i) * PW'(c_i);
      ar_q   <= ar_i;
      ai_q   <= ai_i;
      inv_q  <= inverse_i;
    end
  end

  always_comb begin
    tr = (MW+1)'(mq(m_rc_q)) - (MW+1)'(mq(m_iw_q));
    ti = (MW+1)'(mq(m_rw_q)) + (MW+1)'(mq(m_ic_q));
    s0 = SW'(ar_q) + SW'(tr);
    s1 = SW'(ai_q) + SW'(ti);
    d0 = SW'(ar_q) - SW'(tr);
    d1 = SW'(ai_q) - SW'(ti);
  end

  assign pr_o = fin(s0, inv_q);
  assign pi_o = fin(s1, inv_q);
  assign qr_o = fin(d0, inv_q);
  assign qi_o = fin(d1, inv_q);

endmodule

// ===== sim/tb_spectral_noise_gate_overlap_add.sv =====
`timescale 1ns / 1ps
module tb_spectral_noise_gate_overlap_add;

  localparam int unsigned N         = sngoa_pkg::FFT_SIZE_DEF;
  localparam int unsigned HALF      = N / 2;
  localparam int unsigned LIMIT     = 1000000;
  localparam int unsigned SETTLE    = 12000;
  localparam logic [sngoa_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [sngoa_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam longint unsigned PMAX  = (64'd1 << sngoa_pkg::POW_W) - 64'd1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               vld;
  } gated_out_t;

  class gate_scoreboard;
    longint          tw_c[HALF];
    longint          tw_s[HALF];
    int              frame_buf[N];
    longint unsigned avg_pow[N];
    longint          wre[N];
    longint          wim[N];
    int              ola_tail[HALF];
    int              ola_out[HALF];
    int unsigned     pos;
    longint unsigned lam;
    longint unsigned ratio;
    gated_out_t      pending_q[$];
    int unsigned     errors;

    function longint taylor(longint unsigned x, bit is_cos);
      longint unsigned x2;
      longint unsigned t;
      longint          s;
      x2 = (x * x) >> 30;
      t  = is_cos ? (64'd1 << 30) : x;
      s  = longint'(t);
      for (int n = 1; n <= (is_cos ? 9 : 8); n++) begin
        if (is_cos) t = ((t * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
        else t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) s = s - longint'(t);
        else s = s + longint'(t);
      end
      return (s + 64'sd32) >>> 6;
    endfunction

    function void reset_state();
      longint unsigned x;
      int unsigned     m;
      for (int k = 0; k < HALF; k++) begin
        m = (k <= N / 4) ? k : HALF - k;
        x = (longint'(m) * sngoa_pkg::TWO_PI_Q30) / N;
        tw_c[k] = (k <= N / 4) ? taylor(x, 1) : -taylor(x, 1);
        tw_s[k] = taylor(x, 0);
      end
      foreach (frame_buf[i]) frame_buf[i] = 0;
      foreach (avg_pow[i]) avg_pow[i] = 0;
      foreach (ola_tail[i]) begin
        ola_tail[i] = 0;
        ola_out[i]  = 0;
      end
      pos    = 0;
      lam    = sngoa_pkg::LAM_RST;
      ratio  = sngoa_pkg::RATIO_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [sngoa_pkg::CFG_IDX_W-1:0] idx,
                            logic [sngoa_pkg::CFG_DATA_W-1:0] data);
      if (idx == sngoa_pkg::REG_SMOOTH) lam = data[sngoa_pkg::LAM_W-1:0];
      else if (idx == sngoa_pkg::REG_GATE) ratio = data[sngoa_pkg::RATIO_W-1:0];
    endfunction

    function longint mulq(longint a, longint w);
      return (a * w + (64'sd1 << 23)) >>> 24;
    endfunction

    function longint sat(longint v, int bits);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function void transform(bit inv);
      int unsigned r;
      int unsigned hl;
      int unsigned k;
      int unsigned q;
      longint      t;
      longint      c;
      longint      w;
      longint      tr;
      longint      ti;
      longint      s0;
      longint      s1;
      longint      d0;
      longint      d1;
      for (int i = 0; i < N; i++) begin
        r = 0;
        for (int b = 0; b < $clog2(N); b++) r |= ((i >> b) & 1) << ($clog2(N) - 1 - b);
        if (r > i) begin
          t = wre[i]; wre[i] = wre[r]; wre[r] = t;
          t = wim[i]; wim[i] = wim[r]; wim[r] = t;
        end
      end
      for (int len = 2; len <= N; len = len * 2) begin
        hl = len / 2;
        for (int base = 0; base < N; base += len) begin
          for (int j = 0; j < hl; j++) begin
            k  = (j * (N / len)) % HALF;
            c  = tw_c[k];
            w  = inv ? tw_s[k] : -tw_s[k];
            q  = base + j + hl;
            tr = mulq(wre[q], c) - mulq(wim[q], w);
            ti = mulq(wre[q], w) + mulq(wim[q], c);
            s0 = wre[base + j] + tr;
            s1 = wim[base + j] + ti;
            d0 = wre[base + j] - tr;
            d1 = wim[base + j] - ti;
            if (inv) begin
              s0 = (s0 + 1) >>> 1; s1 = (s1 + 1) >>> 1;
              d0 = (d0 + 1) >>> 1; d1 = (d1 + 1) >>> 1;
            end
            wre[base + j] = s0; wim[base + j] = s1;
            wre[q] = d0; wim[q] = d1;
          end
        end
      end
    endfunction

    function void gate_frame(int unsigned n);
      longint unsigned ar;
      longint unsigned ai;
      longint unsigned pw;
      longint          a;
      longint          b;
      for (int i = 0; i < N; i++) begin
        wre[i] = frame_buf[(n + 1 + i) % N];
        wim[i] = 0;
      end
      transform(0);
      for (int i = 0; i < N; i++) begin
        ar = wre[i] < 0 ? -wre[i] : wre[i];
        ai = wim[i] < 0 ? -wim[i] : wim[i];
        if (ar >= (64'd1 << 24) || ai >= (64'd1 << 24)) begin
          pw = PMAX;
        end else begin
          pw = ar * ar + ai * ai;
          if (pw > PMAX) pw = PMAX;
        end
        avg_pow[i] = (lam * avg_pow[i] + (64'd65536 - lam) * pw + 64'd32768) >> 16;
        if (pw < ratio * avg_pow[i]) begin
          wre[i] = 0;
          wim[i] = 0;
        end
      end
      transform(1);
      for (int i = 0; i < HALF; i++) begin
        a = sat((wre[i] + 1) >>> 1, 32);
        b = sat((wre[i + HALF] + 1) >>> 1, 32);
        ola_out[i]  = int'(sat(longint'(ola_tail[i]) + a, sngoa_pkg::SAMPLE_BITS_DEF));
        ola_tail[i] = int'(b);
      end
    endfunction

    function void note_input(logic signed [15:0] smp);
      gated_out_t e;
      frame_buf[pos % N] = smp;
      if (pos >= N) begin
        e.sample = ola_out[pos % HALF];
        e.vld    = 1'b1;
      end else begin
        e = '0;
      end
      pending_q.push_back(e);
      if (pos >= N - 1 && ((pos + 1) % HALF) == 0) gate_frame(pos);
      pos++;
      if (pos >= 2 * N) pos -= N;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check(logic signed [15:0] smp, logic vld);
      gated_out_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected transaction sample %0d valid %0b", smp, vld));
      end else begin
        e = pending_q.pop_front();
        if (smp !== e.sample)
          report($sformatf("sample_out %0d, expected %0d", smp, e.sample));
        if (vld !== e.vld)
          report($sformatf("out_valid %0b, expected %0b", vld, e.vld));
      end
    endtask
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [sngoa_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [sngoa_pkg::CFG_DATA_W-1:0] cfg_data_i;
  sngoa_in_if  in_ch ();
  sngoa_out_if out_ch ();

  spectral_noise_gate_overlap_add dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  gate_scoreboard sb;
  int unsigned    cycles;
  int unsigned    accepted;
  int unsigned    send_idle;
  int unsigned    sink_stall;
  int unsigned    hold_off;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    sb         = new();
    sb.reset_state();
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = sngoa_pkg::REG_SMOOTH;
    cfg_data_i = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    out_ch.ready    = 1'b0;
    cycles     = 0;
    accepted   = 0;
    send_idle  = 0;
    sink_stall = 0;
    hold_off   = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (in_ch.valid && in_ch.ready) begin
      sb.note_input(in_ch.sample_in);
      accepted <= accepted + 1;
    end
    if (out_ch.valid && out_ch.ready) sb.check(out_ch.sample_out, out_ch.out_valid);
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off     <= hold_off - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall);
    end
  end

  task send_sample(logic signed [15:0] smp);
    int unsigned seen;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.sample_in = smp;
    seen = accepted;
    do @(negedge clk_i); while (accepted == seen);
  endtask

  task drain();
    in_ch.valid = 1'b0;
    while (sb.pending_q.size() > 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task write_reg(logic [sngoa_pkg::CFG_IDX_W-1:0] idx,
                 logic [sngoa_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample(int unsigned idx);
    case ($urandom_range(3))
      0:       return 16'($urandom_range(511)) - 16'sd256;
      1:       return 16'($urandom);
      2:       return ((idx >> 3) & 1) ? 16'sd24000 : -16'sd24000;
      default: return 16'($urandom_range(15));
    endcase
  endfunction

  task run_phase(int unsigned count, int unsigned idle, int unsigned stall);
    send_idle  = idle;
    sink_stall = stall;
    for (int i = 0; i < count; i++) send_sample(pick_sample(i));
  endtask

  initial begin
    logic signed [15:0] corner_vals[7];
    corner_vals = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001,
                    16'sh5555, -16'sh5556};
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (corner_vals[i]) send_sample(corner_vals[i]);
    for (int i = 0; i < 18; i++) send_sample(i[0] ? 16'sh7fff : -16'sh8000);
    run_phase(100, 0, 0);
    drain();

    write_reg(sngoa_pkg::REG_SMOOTH, 16'd0);
    write_reg(sngoa_pkg::REG_GATE, 16'd1);
    run_phase(180, 74, 0);
    drain();

    write_reg(sngoa_pkg::REG_SMOOTH, 16'hffff);
    write_reg(sngoa_pkg::REG_GATE, 16'd1023);
    hold_off = 3000;
    run_phase(180, 0, 74);
    drain();

    write_reg(sngoa_pkg::REG_GATE, 16'd0);
    write_reg(sngoa_pkg::REG_SMOOTH, 16'd32768);
    write_reg(REG_SPARE_A, 16'hffff);
    write_reg(REG_SPARE_B, 16'h1234);
    run_phase(180, 21, 21);
    drain();

    write_reg(sngoa_pkg::REG_SMOOTH, 16'd65470);
    write_reg(sngoa_pkg::REG_GATE, 16'hfc0a);
    run_phase(110, 21, 21);
    for (int i = 0; i < 130; i++) send_sample(16'sd0);
    drain();

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
